@@ hdl/mbc1_bank_controller_macros.svh @@
// Assertion macros for the verification files of the bank controller (used by mbc1_checker).
`ifndef MBC1_BANK_CONTROLLER_MACROS_SVH
`define MBC1_BANK_CONTROLLER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MBC1_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MBC1_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define MBC1_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/mbc1_pkg.sv @@
`default_nettype none

package mbc1_pkg;

  localparam int RAM_BYTES_DEF = 32768;
  // full cartridge RAM offset: 2-bit bank and 13-bit offset in the bank
  localparam int RAM_IDX_W     = 15;
  localparam int ROM_ADDR_W    = 21;
  localparam int CFG_W         = 8;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_ROM_BANKS = 1'd0;
  localparam cfg_idx_t REG_RAM_BANKS = 1'd1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [RAM_IDX_W-1:0] idx;
    logic [7:0]           wdata;
  } ram_req_t;

  typedef struct packed {
    logic                  use_ram;
    logic [7:0]            read_data;
    logic                  from_rom;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  unsupported;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/mbc1_ram.sv @@
`default_nettype none

module mbc1_ram #(
  parameter int RAM_BYTES = mbc1_pkg::RAM_BYTES_DEF
) (
  input  wire                  clk,
  input  mbc1_pkg::ram_req_t   req,
  output logic [7:0]           q
);
  import mbc1_pkg::*;

  // RAM_BYTES is a power of two, so the wrap is the low address bits
  localparam int AW = $clog2(RAM_BYTES);

  logic [7:0] mem [RAM_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.idx[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.idx[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ hdl/mbc1_regs.sv @@
`default_nettype none

module mbc1_regs (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  mbc1_pkg::cfg_idx_t          cfg_index,
  input  wire [mbc1_pkg::CFG_W-1:0]   cfg_data,
  input  wire                         acc,
  input  wire                         cmd,
  input  wire [15:0]                  address,
  input  wire [7:0]                   write_data,
  output mbc1_pkg::ram_req_t          ram_req,
  output mbc1_pkg::result_t           result
);
  import mbc1_pkg::*;

  // address[15:13] regions
  localparam logic [2:0] RGN_RAM_EN = 3'd0;
  localparam logic [2:0] RGN_LOW    = 3'd1;
  localparam logic [2:0] RGN_UPPER  = 3'd2;
  localparam logic [2:0] RGN_MODE   = 3'd3;
  localparam logic [2:0] RGN_CRAM   = 3'd5;

  logic [7:0] rom_bank_count;
  logic [2:0] ram_bank_count;
  logic       ram_enabled, ram_enabled_next;
  logic [4:0] low_bank, low_bank_next;
  logic [1:0] upper_bank, upper_bank_next;
  logic       advanced_mode, advanced_mode_next;

  logic       has_ram, ram_multi, ram_over2, rom_big, upper_rom;
  logic [1:0] rom_hi;
  logic [1:0] ram_bank;
  logic [4:0] low_sel, low_mask;
  logic [1:0] upper_sel;

  assign has_ram   = ram_bank_count != 3'd0;
  assign ram_multi = ram_bank_count >= 3'd2;
  assign ram_over2 = ram_bank_count >= 3'd3;
  assign rom_big   = rom_bank_count > 8'd32;
  assign upper_rom = advanced_mode && rom_big;
  assign rom_hi    = upper_rom ? upper_bank : 2'd0;
  assign ram_bank  = (advanced_mode && !rom_big) ? upper_bank : 2'd0;

  always_comb begin
    if (rom_bank_count <= 8'd2)       low_mask = 5'h01;
    else if (rom_bank_count <= 8'd4)  low_mask = 5'h03;
    else if (rom_bank_count <= 8'd8)  low_mask = 5'h07;
    else if (rom_bank_count <= 8'd16) low_mask = 5'h0F;
    else                              low_mask = 5'h1F;
    low_sel = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
    low_sel = low_sel & low_mask;

    upper_sel = write_data[1:0];
    if (rom_big) begin
      if (rom_bank_count <= 8'd64) upper_sel[1] = 1'b0;
    end else if (!ram_multi) begin
      upper_sel = 2'd0;
    end else if (!ram_over2) begin
      upper_sel[1] = 1'b0;
    end
  end

  always_comb begin
    ram_enabled_next   = ram_enabled;
    low_bank_next      = low_bank;
    upper_bank_next    = upper_bank;
    advanced_mode_next = advanced_mode;

    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.idx   = {ram_bank, address[12:0]};
    ram_req.wdata = write_data;

    result = '0;

    if (cmd == CMD_READ) begin
      if (!address[15]) begin
        result.from_rom    = 1'b1;
        result.rom_address = address[14] ? {rom_hi, low_bank, address[13:0]}
                                         : {rom_hi, 5'd0, address[13:0]};
      end else if (address[15:13] == RGN_CRAM && has_ram) begin
        result.use_ram   = ram_enabled;
        result.read_data = 8'hFF;
        ram_req.re       = acc && ram_enabled;
      end else begin
        result.read_data   = 8'hFF;
        result.unsupported = 1'b1;
      end
    end else begin
      case (address[15:13])
        RGN_RAM_EN: begin
          if (has_ram) ram_enabled_next = write_data[3:0] == 4'hA;
          else         result.unsupported = 1'b1;
        end
        RGN_LOW:   low_bank_next = low_sel;
        RGN_UPPER: upper_bank_next = upper_sel;
        RGN_MODE: begin
          if (rom_big || ram_multi) advanced_mode_next = write_data[0];
        end
        RGN_CRAM: begin
          if (has_ram) ram_req.we = acc && ram_enabled;
          else         result.unsupported = 1'b1;
        end
        default: result.unsupported = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= 8'd2;
      ram_bank_count <= 3'd0;
      ram_enabled    <= 1'b0;
      low_bank       <= 5'd1;
      upper_bank     <= 2'd0;
      advanced_mode  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROM_BANKS: rom_bank_count <= cfg_data;
          REG_RAM_BANKS: ram_bank_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (acc) begin
        ram_enabled   <= ram_enabled_next;
        low_bank      <= low_bank_next;
        upper_bank    <= upper_bank_next;
        advanced_mode <= advanced_mode_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mbc1_bank_controller.sv @@
// Channel   Dir  Ready  tdata (low bit up)                         tuser
// s_axis    in   yes    address[15:0], write_data[23:16]           cmd
// m_axis    out  yes    read_data[7:0], rom_address[28:8], 0 pad    from_rom, unsupported
// cfg       in   no     cfg_index selects register, cfg_data value  -
//
// One transaction per cycle sustained while m_axis_tready is high; the result
// passes the RAM stage (bank decode + cartridge RAM read), then the output register.
// The cartridge RAM has one synchronous port; a write lands before the next
// access reads it, so no forwarding is needed.
// rst is synchronous; it resets bank registers and config to their defaults and
// clears both stage valids; RAM contents are not cleared.
// Input is taken whenever the RAM stage is free, the output register is free, or m_axis_tready drains the output.
`default_nettype none

module mbc1_bank_controller #(
  parameter int RAM_BYTES = mbc1_pkg::RAM_BYTES_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  mbc1_pkg::cfg_idx_t         cfg_index,
  input  wire [mbc1_pkg::CFG_W-1:0]  cfg_data,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire [23:0]                 s_axis_tdata,  // address, write_data
  input  wire                        s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // read_data, rom_address, pad
  output logic [1:0]                 m_axis_tuser   // from_rom, unsupported
);
  import mbc1_pkg::*;

  logic      acc, move1;
  logic      v1;
  result_t   res, res1;
  ram_req_t  ram_req;
  logic [7:0] ram_q;

  logic                  out_valid;
  logic [7:0]            out_read_data;
  logic                  out_from_rom;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic                  out_unsupported;

  assign move1         = v1 && (!out_valid || m_axis_tready);
  assign s_axis_tready = !v1 || move1;
  assign acc           = s_axis_tvalid && s_axis_tready;

  mbc1_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .acc        (acc),
    .cmd        (s_axis_tuser),
    .address    (s_axis_tdata[15:0]),
    .write_data (s_axis_tdata[23:16]),
    .ram_req    (ram_req),
    .result     (res)
  );

  mbc1_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk (clk),
    .req (ram_req),
    .q   (ram_q)
  );

  // RAM stage: holds the decoded result while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (acc) begin
      v1 <= 1'b1;
    end else if (move1) begin
      v1 <= 1'b0;
    end
    if (acc) begin
      res1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move1) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (move1) begin
      out_read_data   <= res1.use_ram ? ram_q : res1.read_data;
      out_from_rom    <= res1.from_rom;
      out_rom_address <= res1.rom_address;
      out_unsupported <= res1.unsupported;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_rom_address, out_read_data};
  assign m_axis_tuser  = {out_unsupported, out_from_rom};

endmodule

`default_nettype wire

@@ hdl/mbc1_checker.sv @@
`default_nettype none

`include "mbc1_bank_controller_macros.svh"

module mbc1_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  logic in_xact;

  assign in_xact = s_axis_tvalid && s_axis_tready;

  `MBC1_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid, "output valid after reset")

  `MBC1_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output changed")

  `MBC1_ASSERT_IMPL(a_rom_clean, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[7:0] == 8'h00 && !m_axis_tuser[1],
    "ROM result carries RAM data or error")

  `MBC1_ASSERT_IMPL(a_latency, in_xact && !m_axis_tvalid, ##2 m_axis_tvalid,
    "transaction result did not appear after two cycles")

endmodule

bind mbc1_bank_controller mbc1_checker u_checker (.*);

`default_nettype wire
